>>> rtl/srq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizing for the sequence reorder queue.
// Used by srq_slot_ram, srq_seq, sequence_reorder_queue and the bench; depends on nothing.
package srq_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STS_INSERTED  = 3'd0,
		STS_DUPLICATE = 3'd1,
		STS_FULL      = 3'd2,
		STS_POPPED    = 3'd3,
		STS_NOT_READY = 3'd4,
		STS_CLEARED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_SHIFT,
		SEQ_PLACE,
		SEQ_HEAD_RD,
		SEQ_HEAD_CHK,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] bytes;
		logic [15:0] handle;
	} slot_t;

	// Completion of one operation, handed from the sequencer to the top level
	typedef struct packed {
		logic        valid;
		status_t     status;
		slot_t       popped;
		logic [15:0] pkt_bytes;
	} done_t;

endpackage

>>> rtl/sequence_reorder_queue.sv
`timescale 1ns / 1ps
// Top level of the sequence reorder queue: handshakes, counters, result register.
// Depends on srq_pkg, srq_slot_ram and srq_seq.
//
// Holds up to DEPTH packets (id, byte size, handle) sorted by ascending 32-bit
// id in a single-port-read slot RAM. One beat in gives one beat out, except op
// three, which is dropped with no result. An insert first searches the table
// from the lowest id and stops at the first id not below the new one (equal
// means duplicate), then moves the larger entries up one slot and writes the
// new one; a pop reads slot zero, compares it with the expected id and, on a
// match, moves the rest down one slot. The held entries pass through the one
// RAM read port about once per insert or successful pop, so the time follows
// the entry count. On a full table an insert that finds no duplicate reports
// full. The next beat can be taken the cycle after the result moves on. The
// input is not ready while an operation runs, and a finished result waits in
// the output register while the next beat is taken. Clear zeroes entry count,
// byte total and transaction count but keeps the expected id. No clearing
// pass is needed after reset: slots at or above the entry count are never read.
module sequence_reorder_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] packet_id,
	input  logic [15:0] packet_bytes,
	input  logic [15:0] packet_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] out_id,
	output logic [15:0] out_bytes,
	output logic [15:0] out_handle,
	output logic [6:0]  entry_count,
	output logic [21:0] byte_total,
	output logic [31:0] expected_id,
	output logic [31:0] transactions
);

	localparam int CW = srq_pkg::CNT_W;
	localparam int IW = srq_pkg::IDX_W;

	// Architectural counters
	logic [CW-1:0] held_q, held_d;
	logic [31:0]   expected_q, expected_d;
	logic [22:0]   bytes_q, bytes_d;
	logic [31:0]   ops_q, ops_d;

	// Result register
	logic             out_valid_q;
	srq_pkg::status_t status_q;
	srq_pkg::slot_t   popped_q;
	logic [6:0]       count_q;
	logic [21:0]      total_q;
	logic [31:0]      exp_out_q;
	logic [31:0]      ops_out_q;

	logic           in_fire;
	logic           done_ready;
	logic           done_fire;
	logic           seq_idle;
	srq_pkg::done_t done;
	srq_pkg::slot_t pkt;
	logic [CW+6:0]  held_wide;

	logic           rd_en;
	logic [IW-1:0]  rd_addr;
	srq_pkg::slot_t rd_data;
	logic           wr_en;
	logic [IW-1:0]  wr_addr;
	srq_pkg::slot_t wr_data;

	assign pkt.id     = packet_id;
	assign pkt.bytes  = packet_bytes;
	assign pkt.handle = packet_handle;

	// Take a beat only while the sequencer is idle
	assign in_ready   = seq_idle;
	assign in_fire    = in_valid && in_ready;
	// Hand a result over once the output register is free or draining
	assign done_ready = !out_valid_q || out_ready;
	assign done_fire  = done.valid && done_ready;

	srq_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_fire),
		.op         (op),
		.pkt        (pkt),
		.held       (held_q),
		.expected   (expected_q),
		.done_ready (done_ready),
		.idle       (seq_idle),
		.done       (done),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	srq_slot_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Counter update from the outcome of the finished operation
	always_comb begin
		held_d     = held_q;
		expected_d = expected_q;
		bytes_d    = bytes_q;
		ops_d      = ops_q;
		if (done_fire) begin
			unique case (done.status)
				srq_pkg::STS_INSERTED: begin
					held_d  = held_q + CW'(1);
					bytes_d = bytes_q + 23'(done.pkt_bytes);
					ops_d   = ops_q + 32'd1;
				end
				srq_pkg::STS_POPPED: begin
					held_d     = held_q - CW'(1);
					bytes_d    = bytes_q - 23'(done.popped.bytes);
					expected_d = expected_q + 32'd1;
					ops_d      = ops_q + 32'd1;
				end
				srq_pkg::STS_CLEARED: begin
					held_d  = '0;
					bytes_d = '0;
					ops_d   = '0;
				end
				default: ops_d = ops_q + 32'd1;
			endcase
		end
	end

	// Zero-extend before taking the low seven bits, whatever the count width
	assign held_wide = {7'd0, held_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			expected_q  <= '0;
			bytes_q     <= '0;
			ops_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			held_q     <= held_d;
			expected_q <= expected_d;
			bytes_q    <= bytes_d;
			ops_q      <= ops_d;
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result fields until the next result is loaded
	always_ff @(posedge clk) begin
		if (done_fire) begin
			status_q  <= done.status;
			popped_q  <= done.popped;
			count_q   <= held_wide[6:0];
			total_q   <= bytes_d[21:0];
			exp_out_q <= expected_d;
			ops_out_q <= ops_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_id       = popped_q.id;
	assign out_bytes    = popped_q.bytes;
	assign out_handle   = popped_q.handle;
	assign entry_count  = count_q;
	assign byte_total   = total_q;
	assign expected_id  = exp_out_q;
	assign transactions = ops_out_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(srq_pkg::DEPTH))
		else $error("entry count above table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == srq_pkg::OP_INSERT || op == srq_pkg::OP_POP
		|| op == srq_pkg::OP_CLEAR)) |=> !in_ready)
		else $error("sequencer stayed idle after an accepted operation");

	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && done.status == srq_pkg::STS_POPPED)
		|=> expected_q == $past(expected_q) + 32'd1)
		else $error("expected id did not advance on pop");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && done.status == srq_pkg::STS_INSERTED)
		|=> held_q == $past(held_q) + CW'(1))
		else $error("entry count did not grow on insert");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> out_valid_q && ops_out_q == ops_q)
		else $error("result register not loaded with the new counters");

endmodule

>>> rtl/srq_slot_ram.sv
`timescale 1ns / 1ps
// Slot storage: one write port and one registered read port.
// Depends on srq_pkg for the slot type and depth.
module srq_slot_ram (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [srq_pkg::IDX_W-1:0] wr_addr,
	input  srq_pkg::slot_t           wr_data,
	input  logic                     rd_en,
	input  logic [srq_pkg::IDX_W-1:0] rd_addr,
	output srq_pkg::slot_t           rd_data
);

	srq_pkg::slot_t mem_q [srq_pkg::DEPTH];
	srq_pkg::slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/srq_seq.sv
`timescale 1ns / 1ps
// Operation sequencer: search, shift and place over the slot RAM with one
// shared id comparator. Depends on srq_pkg; drives srq_slot_ram ports.
module srq_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                op,
	input  srq_pkg::slot_t            pkt,
	input  logic [srq_pkg::CNT_W-1:0] held,
	input  logic [31:0]               expected,
	input  logic                      done_ready,
	output logic                      idle,
	output srq_pkg::done_t            done,
	output logic                      rd_en,
	output logic [srq_pkg::IDX_W-1:0] rd_addr,
	input  srq_pkg::slot_t            rd_data,
	output logic                      wr_en,
	output logic [srq_pkg::IDX_W-1:0] wr_addr,
	output srq_pkg::slot_t            wr_data
);

	localparam int CW = srq_pkg::CNT_W;
	localparam int IW = srq_pkg::IDX_W;

	srq_pkg::seq_state_t state_q, state_d;
	logic                v_s1;
	logic [IW-1:0]       addr_s1;
	logic [1:0]          op_q;
	srq_pkg::slot_t      pkt_q;
	srq_pkg::slot_t      res_q;
	srq_pkg::status_t    status_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       pos_q;

	logic [31:0] cmp_opnd;
	logic        cmp_eq;
	logic        cmp_gt;
	logic        hit;
	logic        scan_end;
	logic        is_full;
	logic        ins;

	// Shared comparator: stored id against the key or the expected id
	assign cmp_opnd = (state_q == srq_pkg::SEQ_HEAD_CHK) ? expected : pkt_q.id;
	assign cmp_eq   = rd_data.id == cmp_opnd;
	assign cmp_gt   = rd_data.id > cmp_opnd;
	assign hit      = v_s1 && (cmp_eq || cmp_gt);
	assign scan_end = !v_s1 && (idx_q >= held);
	assign is_full  = held >= CW'(srq_pkg::DEPTH);
	assign ins      = op_q == srq_pkg::OP_INSERT;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		unique case (state_q)
			srq_pkg::SEQ_SCAN: begin
				rd_en   = (idx_q < held) && !hit;
				rd_addr = idx_q[IW-1:0];
			end
			srq_pkg::SEQ_SHIFT: begin
				rd_en   = cnt_q != '0;
				rd_addr = idx_q[IW-1:0];
				if (v_s1) begin
					wr_en   = 1'b1;
					wr_addr = ins ? addr_s1 + IW'(1) : addr_s1 - IW'(1);
				end
			end
			srq_pkg::SEQ_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[IW-1:0];
				wr_data = pkt_q;
			end
			srq_pkg::SEQ_HEAD_RD: begin
				rd_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srq_pkg::SEQ_IDLE: begin
				if (start) begin
					case (srq_pkg::op_t'(op))
						srq_pkg::OP_INSERT: state_d = srq_pkg::SEQ_SCAN;
						srq_pkg::OP_POP:
							state_d = (held == '0) ? srq_pkg::SEQ_DONE : srq_pkg::SEQ_HEAD_RD;
						srq_pkg::OP_CLEAR:  state_d = srq_pkg::SEQ_DONE;
						default:            state_d = srq_pkg::SEQ_IDLE;
					endcase
				end
			end
			srq_pkg::SEQ_SCAN: begin
				if (hit) begin
					state_d = (cmp_eq || is_full) ? srq_pkg::SEQ_DONE : srq_pkg::SEQ_SHIFT;
				end else if (scan_end) begin
					state_d = is_full ? srq_pkg::SEQ_DONE : srq_pkg::SEQ_SHIFT;
				end
			end
			srq_pkg::SEQ_SHIFT: begin
				if (cnt_q == '0 && !v_s1) begin
					state_d = ins ? srq_pkg::SEQ_PLACE : srq_pkg::SEQ_DONE;
				end
			end
			srq_pkg::SEQ_PLACE:    state_d = srq_pkg::SEQ_DONE;
			srq_pkg::SEQ_HEAD_RD:  state_d = srq_pkg::SEQ_HEAD_CHK;
			srq_pkg::SEQ_HEAD_CHK:
				state_d = cmp_eq ? srq_pkg::SEQ_SHIFT : srq_pkg::SEQ_DONE;
			srq_pkg::SEQ_DONE: begin
				if (done_ready) begin
					state_d = srq_pkg::SEQ_IDLE;
				end
			end
			default: state_d = srq_pkg::SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srq_pkg::SEQ_IDLE;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		unique case (state_q)
			srq_pkg::SEQ_IDLE: begin
				if (start) begin
					op_q     <= op;
					pkt_q    <= pkt;
					idx_q    <= '0;
					cnt_q    <= '0;
					res_q    <= '0;
					status_q <= (op == srq_pkg::OP_CLEAR) ? srq_pkg::STS_CLEARED
					                                      : srq_pkg::STS_NOT_READY;
				end
			end
			srq_pkg::SEQ_SCAN: begin
				if (rd_en) begin
					idx_q <= idx_q + CW'(1);
				end
				if (hit) begin
					if (cmp_eq) begin
						status_q <= srq_pkg::STS_DUPLICATE;
					end else begin
						status_q <= srq_pkg::STS_FULL;
						pos_q    <= CW'(addr_s1);
						idx_q    <= held - CW'(1);
						cnt_q    <= held - CW'(addr_s1);
					end
				end else if (scan_end) begin
					status_q <= srq_pkg::STS_FULL;
					pos_q    <= held;
					cnt_q    <= '0;
				end
			end
			srq_pkg::SEQ_SHIFT: begin
				if (rd_en) begin
					idx_q <= ins ? idx_q - CW'(1) : idx_q + CW'(1);
					cnt_q <= cnt_q - CW'(1);
				end
			end
			srq_pkg::SEQ_PLACE: status_q <= srq_pkg::STS_INSERTED;
			srq_pkg::SEQ_HEAD_CHK: begin
				if (cmp_eq) begin
					res_q    <= rd_data;
					status_q <= srq_pkg::STS_POPPED;
					idx_q    <= CW'(1);
					cnt_q    <= held - CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign idle             = state_q == srq_pkg::SEQ_IDLE;
	assign done.valid       = state_q == srq_pkg::SEQ_DONE;
	assign done.status      = status_q;
	assign done.popped      = res_q;
	assign done.pkt_bytes   = pkt_q.bytes;

endmodule

>>> tb/sv/srq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sequence reorder queue: keeps a shadow of the sorted
// table, predicts one result beat per accepted op other than op three and
// compares field by field. Depends on srq_pkg.
module srq_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] packet_id,
	input  logic [15:0] packet_bytes,
	input  logic [15:0] packet_handle,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [31:0] out_id,
	input  logic [15:0] out_bytes,
	input  logic [15:0] out_handle,
	input  logic [6:0]  entry_count,
	input  logic [21:0] byte_total,
	input  logic [31:0] expected_id,
	input  logic [31:0] transactions,
	output int          fail_count,
	output int          outstanding
);

	typedef struct {
		srq_pkg::status_t status;
		logic [31:0]      id;
		logic [15:0]      bytes;
		logic [15:0]      handle;
		logic [6:0]       count;
		logic [21:0]      total;
		logic [31:0]      next_id;
		logic [31:0]      txn;
	} outcome_t;

	outcome_t expected_outcomes[$];

	logic [31:0] shadow_id     [srq_pkg::DEPTH];
	logic [15:0] shadow_bytes  [srq_pkg::DEPTH];
	logic [15:0] shadow_handle [srq_pkg::DEPTH];
	int          held       = 0;
	logic [31:0] release_id = '0;
	logic [22:0] held_sum   = '0;
	logic [31:0] txn_count  = '0;

	int n_fail = 0;
	int n_open = 0;

	assign fail_count  = n_fail;
	assign outstanding = n_open;

	task automatic report_error(input string msg);
		$display("[%0t] srq mismatch: %s", $time, msg);
		n_fail++;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// Apply one accepted op to the shadow table and queue the beat it causes
	task automatic predict_outcome(input logic [1:0] b_op, input logic [31:0] b_id,
			input logic [15:0] b_bytes, input logic [15:0] b_handle);
		outcome_t o;
		int       i;
		int       pos;
		bit       dup;
		o.status = srq_pkg::STS_CLEARED;
		o.id     = '0;
		o.bytes  = '0;
		o.handle = '0;
		case (b_op)
			srq_pkg::OP_INSERT: begin
				txn_count++;
				dup = 0;
				pos = held;
				for (i = 0; i < held && !dup; i++) begin
					if (shadow_id[i] == b_id)
						dup = 1;
					else if (shadow_id[i] > b_id && pos == held)
						pos = i;
				end
				if (dup) begin
					o.status = srq_pkg::STS_DUPLICATE;
				end else if (held >= srq_pkg::DEPTH) begin
					o.status = srq_pkg::STS_FULL;
				end else begin
					for (i = held; i > pos; i--) begin
						shadow_id[i]     = shadow_id[i - 1];
						shadow_bytes[i]  = shadow_bytes[i - 1];
						shadow_handle[i] = shadow_handle[i - 1];
					end
					shadow_id[pos]     = b_id;
					shadow_bytes[pos]  = b_bytes;
					shadow_handle[pos] = b_handle;
					held++;
					held_sum = held_sum + b_bytes;
					o.status = srq_pkg::STS_INSERTED;
				end
			end
			srq_pkg::OP_POP: begin
				txn_count++;
				if (held == 0 || shadow_id[0] != release_id) begin
					o.status = srq_pkg::STS_NOT_READY;
				end else begin
					o.id     = shadow_id[0];
					o.bytes  = shadow_bytes[0];
					o.handle = shadow_handle[0];
					for (i = 1; i < held; i++) begin
						shadow_id[i - 1]     = shadow_id[i];
						shadow_bytes[i - 1]  = shadow_bytes[i];
						shadow_handle[i - 1] = shadow_handle[i];
					end
					held--;
					held_sum   = held_sum - o.bytes;
					release_id = release_id + 1;
					o.status   = srq_pkg::STS_POPPED;
				end
			end
			srq_pkg::OP_CLEAR: begin
				held      = 0;
				held_sum  = '0;
				txn_count = '0;
				o.status  = srq_pkg::STS_CLEARED;
			end
			default: return;
		endcase
		o.count   = held[6:0];
		o.total   = held_sum[21:0];
		o.next_id = release_id;
		o.txn     = txn_count;
		expected_outcomes.push_back(o);
	endtask

	task automatic check_result();
		outcome_t w;
		if (expected_outcomes.size() == 0) begin
			report_error($sformatf("result beat with nothing pending, status %0d", status));
			return;
		end
		w = expected_outcomes.pop_front();
		cmp_field("status", status, w.status);
		cmp_field("out_id", out_id, w.id);
		cmp_field("out_bytes", out_bytes, w.bytes);
		cmp_field("out_handle", out_handle, w.handle);
		cmp_field("entry_count", entry_count, w.count);
		cmp_field("byte_total", byte_total, w.total);
		cmp_field("expected_id", expected_id, w.next_id);
		cmp_field("transactions", transactions, w.txn);
	endtask

	// A result never belongs to the op taken at the same edge: check first
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				predict_outcome(op, packet_id, packet_bytes, packet_handle);
		end
		n_open <= expected_outcomes.size();
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the sequence reorder queue bench: clock, reset, op stimulus and verdict.
// Depends on srq_pkg, sequence_reorder_queue and srq_checker.
module tb;

	localparam int          N_ITEMS       = 900;
	localparam int          CALM_AFTER    = 800;   // no idling past this many ops
	localparam int          STALL_LIMIT   = 2000;  // cycles with no beat on either side
	localparam int          SETTLE_CYCLES = 100;
	localparam logic [1:0]  OP_IGNORED    = 2'd3;  // op code the block drops

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [1:0]  op            = srq_pkg::OP_INSERT;
	logic [31:0] packet_id     = '0;
	logic [15:0] packet_bytes  = '0;
	logic [15:0] packet_handle = '0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [2:0]  status;
	logic [31:0] out_id;
	logic [15:0] out_bytes;
	logic [15:0] out_handle;
	logic [6:0]  entry_count;
	logic [21:0] byte_total;
	logic [31:0] expected_id;
	logic [31:0] transactions;

	int          fail_count;
	int          outstanding;
	bit          idle_on      = 1'b1;
	int          sent         = 0;     // ops taken, dropped op code excluded
	logic [31:0] seen_next_id = '0;    // expected id from the latest result beat

	sequence_reorder_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.packet_id    (packet_id),
		.packet_bytes (packet_bytes),
		.packet_handle(packet_handle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_id       (out_id),
		.out_bytes    (out_bytes),
		.out_handle   (out_handle),
		.entry_count  (entry_count),
		.byte_total   (byte_total),
		.expected_id  (expected_id),
		.transactions (transactions)
	);

	srq_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.packet_id    (packet_id),
		.packet_bytes (packet_bytes),
		.packet_handle(packet_handle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_id       (out_id),
		.out_bytes    (out_bytes),
		.out_handle   (out_handle),
		.entry_count  (entry_count),
		.byte_total   (byte_total),
		.expected_id  (expected_id),
		.transactions (transactions),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Track the release id the block reports, so sessions can start at it
	always @(posedge clk) begin
		if (out_valid && out_ready)
			seen_next_id <= expected_id;
	end

	// Result side: stall in bursts of random length while idling is on
	initial begin : sink
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stop the run when neither channel moves a beat for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** sequence_reorder_queue: FAILED **");
		$finish;
	end

	// Offer one beat and hold it until taken. Entered and left just after an
	// edge; valid stays high into the next beat unless a gap is inserted.
	task automatic send_beat(input logic [1:0] b_op, input logic [31:0] b_id,
			input logic [15:0] b_bytes, input logic [15:0] b_handle);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		op            <= b_op;
		packet_id     <= b_id;
		packet_bytes  <= b_bytes;
		packet_handle <= b_handle;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (b_op != OP_IGNORED)
			sent++;
	endtask

	task automatic insert_pkt(input logic [31:0] b_id, input logic [15:0] b_bytes,
			input logic [15:0] b_handle);
		send_beat(srq_pkg::OP_INSERT, b_id, b_bytes, b_handle);
	endtask

	task automatic pop_pkt();
		send_beat(srq_pkg::OP_POP, $urandom, 16'($urandom), 16'($urandom));
	endtask

	task automatic clear_table();
		send_beat(srq_pkg::OP_CLEAR, $urandom, 16'($urandom), 16'($urandom));
	endtask

	// Drop valid and hold off until every predicted beat has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] ids [srq_pkg::DEPTH];
		logic [31:0] base;
		logic [31:0] swap;
		int          span;
		int          i;
		int          j;
		bit          big;
		bit          fat;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty pop, id extremes, duplicate, head ahead of expected id,
		// dropped op, clear keeping the release id
		pop_pkt();
		insert_pkt(32'h0000_0000, 16'hFFFF, 16'hFFFF);
		insert_pkt(32'hFFFF_FFFF, 16'h0000, 16'h0000);
		insert_pkt(32'h0000_0000, 16'h1234, 16'h4321);
		insert_pkt(32'h0000_0002, 16'h0001, 16'h8000);
		pop_pkt();
		pop_pkt();
		insert_pkt(32'h0000_0001, 16'h5555, 16'hAAAA);
		pop_pkt();
		pop_pkt();
		send_beat(OP_IGNORED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		insert_pkt(32'h8000_0000, 16'h7FFF, 16'h00FF);
		wait_drained();
		clear_table();
		pop_pkt();
		insert_pkt(32'h0000_0004, 16'hAAAA, 16'h5555);
		insert_pkt(32'h0000_0003, 16'h0FF0, 16'hF00F);
		pop_pkt();
		pop_pkt();
		pop_pkt();
		wait_drained();

		// Random sessions: a shuffled run of ids from the current release id,
		// drained by pops, with duplicates, stray ids and dropped ops mixed in.
		// One session in ten fills the table and pushes past full.
		while (sent < N_ITEMS) begin
			if (sent >= CALM_AFTER)
				idle_on = 1'b0;
			wait_drained();
			base = seen_next_id;
			big  = ($urandom_range(0, 9) == 0);
			fat  = big && ($urandom_range(0, 1) == 1);
			span = big ? srq_pkg::DEPTH : $urandom_range(1, 12);
			if (big)
				clear_table();
			for (i = 0; i < span; i++)
				ids[i] = base + i;
			for (i = span - 1; i > 0; i--) begin
				j      = $urandom_range(0, i);
				swap   = ids[i];
				ids[i] = ids[j];
				ids[j] = swap;
			end
			for (i = 0; i < span; i++) begin
				insert_pkt(ids[i], fat ? 16'hFFFF : 16'($urandom), 16'($urandom));
				if (!big) begin
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4: pop_pkt();
						5:             insert_pkt(ids[$urandom_range(0, i)], 16'($urandom),
						                          16'($urandom));
						6:             send_beat(OP_IGNORED, $urandom, 16'($urandom),
						                         16'($urandom));
						7:             insert_pkt($urandom, 16'($urandom), 16'($urandom));
						8:             insert_pkt(base - 1, 16'($urandom), 16'($urandom));
						default:       ;
					endcase
				end
			end
			if (big) begin
				// Full table: a new id reports full, a held id still reports duplicate
				insert_pkt(base + srq_pkg::DEPTH, 16'($urandom), 16'($urandom));
				insert_pkt(ids[$urandom_range(0, srq_pkg::DEPTH - 1)], 16'($urandom),
				           16'($urandom));
			end
			repeat (span + $urandom_range(0, 2)) pop_pkt();
			if ($urandom_range(0, 2) == 0)
				clear_table();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** sequence_reorder_queue: PASSED **");
		else
			$display("** sequence_reorder_queue: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
rtl/srq_pkg.sv
rtl/srq_slot_ram.sv
rtl/srq_seq.sv
rtl/sequence_reorder_queue.sv
tb/sv/srq_checker.sv
tb/sv/tb.sv
